// ----- rtl/exposure_sweep_frame_averager_defines.svh -----
// Assertion macros for the exposure sweep frame averager.
`ifndef EXPOSURE_SWEEP_FRAME_AVERAGER_DEFINES_SVH
`define EXPOSURE_SWEEP_FRAME_AVERAGER_DEFINES_SVH
// same-cycle implication
`define ESFA_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m failed");
// next-cycle implication
`define ESFA_ASSERT_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("%m failed");
`endif

// ----- rtl/esfa_pkg.sv -----
// Shared constants and types for the exposure sweep frame averager.
package esfa_pkg;
  localparam int MAX_PIXELS = 524288;
  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int POS_W = ADDR_W + 1;
  localparam int DIV_STAGES = 4;

  typedef enum logic [2:0] {
    REG_EXPOSURE_MIN  = 3'd0,
    REG_EXPOSURE_MAX  = 3'd1,
    REG_EXPOSURE_STEP = 3'd2,
    REG_AVERAGE       = 3'd3,
    REG_LAG           = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] exposure_used;
    logic        last_of_image;
    logic [20:0] next_exposure;
    logic        sweep_done;
  } meta_t;

  typedef struct packed {
    logic              emit;
    logic              wr;
    logic              first;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       px;
    logic [7:0]        n;
    meta_t             meta;
  } ctl_t;

  typedef struct packed {
    logic       in_range;
    logic [7:0] n;
    meta_t      meta;
  } tag_t;
endpackage

// ----- rtl/esfa_ctrl.sv -----
// Sweep control: configuration registers, frame and exposure state, stage one.
module esfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [23:0]          pixel_bgr,
  input  logic                 end_of_frame,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [19:0]          cfg_data,
  output logic                 v1,
  output esfa_pkg::ctl_t       c1
);
  import esfa_pkg::*;

  typedef enum logic [1:0] {MODE_IDLE, MODE_SKIP, MODE_SUM} mode_t;

  logic [19:0] exposure_min, exposure_max;
  logic [15:0] exposure_step;
  logic [7:0]  avg_len, lag_frames;

  logic [POS_W-1:0] pos;
  logic [7:0]  frames_summed, skip_r;
  logic [20:0] exp_r;
  mode_t       mode;
  logic        started, finished;

  logic [20:0] cur_exp, next_sum;
  logic [7:0]  skip, skip_e, n_eff;
  mode_t       mode_e;
  logic        is_sum, completing, in_range, emit, wr, acc, done;

  always_comb begin
    cur_exp = started ? exp_r : {1'b0, exposure_min};
    skip = started ? skip_r : lag_frames;
    mode_e = mode;
    skip_e = skip;
    if (mode == MODE_IDLE) begin
      if (skip != 8'd0) begin
        mode_e = MODE_SKIP;
        skip_e = skip - 8'd1;
      end else begin
        mode_e = MODE_SUM;
      end
    end
    n_eff = (avg_len == 8'd0) ? 8'd1 : avg_len;
    is_sum = (mode_e == MODE_SUM);
    completing = ({1'b0, frames_summed} + 9'd1) >= {1'b0, n_eff};
    in_range = pos < POS_W'(MAX_PIXELS);
    next_sum = cur_exp + {5'd0, exposure_step};
    done = end_of_frame && (next_sum > {1'b0, exposure_max});
    emit = is_sum && completing && (in_range || end_of_frame);
    wr = is_sum && in_range;
    acc = in_valid && en && !finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_min <= 20'd0;
      exposure_max <= 20'd1000;
      exposure_step <= 16'd1;
      avg_len <= 8'd10;
      lag_frames <= 8'd10;
      pos <= '0;
      frames_summed <= 8'd0;
      skip_r <= 8'd0;
      exp_r <= 21'd0;
      mode <= MODE_IDLE;
      started <= 1'b0;
      finished <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EXPOSURE_MIN:  exposure_min <= cfg_data;
          REG_EXPOSURE_MAX:  exposure_max <= cfg_data;
          REG_EXPOSURE_STEP: exposure_step <= cfg_data[15:0];
          REG_AVERAGE:       avg_len <= cfg_data[7:0];
          REG_LAG:           lag_frames <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (acc) begin
        started <= 1'b1;
        if (emit && end_of_frame) begin
          exp_r <= next_sum;
          skip_r <= lag_frames;
          finished <= done;
        end else begin
          exp_r <= cur_exp;
          skip_r <= skip_e;
        end
        if (is_sum && end_of_frame)
          frames_summed <= completing ? 8'd0 : frames_summed + 8'd1;
        if (end_of_frame) begin
          pos <= '0;
          mode <= MODE_IDLE;
        end else begin
          if (in_range) pos <= pos + 1'b1;
          mode <= mode_e;
        end
      end
      if (en) v1 <= acc && (emit || wr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1.emit <= emit;
      c1.wr <= wr;
      c1.first <= (frames_summed == 8'd0);
      c1.in_range <= in_range;
      c1.addr <= pos[ADDR_W-1:0];
      c1.px <= pixel_bgr;
      c1.n <= n_eff;
      c1.meta.exposure_used <= cur_exp[19:0];
      c1.meta.last_of_image <= end_of_frame;
      c1.meta.next_exposure <= end_of_frame ? next_sum : 21'd0;
      c1.meta.sweep_done <= done;
    end
  end
endmodule

// ----- rtl/esfa_accum.sv -----
// Per-pixel sum store with read, saturating add and write-back forwarding.
module esfa_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v1,
  input  esfa_pkg::ctl_t       c1,
  output logic                 sum_valid,
  output logic [47:0]          sums,
  output esfa_pkg::tag_t       tag
);
  import esfa_pkg::*;

  logic [47:0] mem [MAX_PIXELS];
  logic [47:0] rd, base, fwd_data;
  logic [ADDR_W-1:0] fwd_addr;
  logic fwd_v, v2;
  ctl_t c2;
  logic [16:0] s [3];

  always_comb begin
    base = (fwd_v && fwd_addr == c2.addr) ? fwd_data : rd;
    for (int i = 0; i < 3; i++) begin
      s[i] = {1'b0, base[16*i +: 16]} + {9'd0, c2.px[8*i +: 8]};
      if (c2.first) sums[16*i +: 16] = {8'd0, c2.px[8*i +: 8]};
      else sums[16*i +: 16] = s[i][16] ? 16'hFFFF : s[i][15:0];
    end
    sum_valid = v2 && c2.emit;
    tag.in_range = c2.in_range;
    tag.n = c2.n;
    tag.meta = c2.meta;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd <= mem[c1.addr];
      c2 <= c1;
      if (v2 && c2.wr) begin
        mem[c2.addr] <= sums;
        fwd_data <= sums;
        fwd_addr <= c2.addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      fwd_v <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      if (v2 && c2.wr) fwd_v <= 1'b1;
    end
  end
endmodule

// ----- rtl/esfa_div.sv -----
// Pipelined divide of three channel sums by the frame count, round half to even.
module esfa_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [47:0]          sums,
  input  esfa_pkg::tag_t       tag_in,
  output logic                 out_valid,
  output logic [23:0]          avg,
  output esfa_pkg::meta_t      meta
);
  import esfa_pkg::*;

  // {remainder, partial quotient / remaining dividend}
  function automatic logic [23:0] step4(input logic [23:0] st, input logic [7:0] n);
    logic [7:0]  rem;
    logic [15:0] num;
    logic [8:0]  r9;
    rem = st[23:16];
    num = st[15:0];
    for (int k = 0; k < 4; k++) begin
      r9 = {rem, num[15]};
      num = {num[14:0], 1'b0};
      if (r9 >= {1'b0, n}) begin
        r9 = r9 - {1'b0, n};
        num[0] = 1'b1;
      end
      rem = r9[7:0];
    end
    return {rem, num};
  endfunction

  logic [23:0] st [DIV_STAGES][3];
  tag_t        tg [DIV_STAGES];
  logic        vs [DIV_STAGES];
  logic [8:0]  twice [3];
  logic [16:0] q [3];
  logic [23:0] avg_c;
  logic        up;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      twice[i] = {st[DIV_STAGES-1][i][23:16], 1'b0};
      up = (twice[i] > {1'b0, tg[DIV_STAGES-1].n}) ||
           (twice[i] == {1'b0, tg[DIV_STAGES-1].n} && st[DIV_STAGES-1][i][0]);
      q[i] = {1'b0, st[DIV_STAGES-1][i][15:0]} + {16'd0, up};
      avg_c[8*i +: 8] = !tg[DIV_STAGES-1].in_range ? 8'd0 :
                        (q[i] > 17'd255) ? 8'hFF : q[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        st[0][i] <= step4({8'd0, sums[16*i +: 16]}, tag_in.n);
        for (int j = 1; j < DIV_STAGES; j++) st[j][i] <= step4(st[j-1][i], tg[j-1].n);
      end
      tg[0] <= tag_in;
      for (int j = 1; j < DIV_STAGES; j++) tg[j] <= tg[j-1];
      avg <= avg_c;
      meta <= tg[DIV_STAGES-1].meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_STAGES; j++) vs[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
      for (int j = 1; j < DIV_STAGES; j++) vs[j] <= vs[j-1];
      out_valid <= vs[DIV_STAGES-1];
    end
  end
endmodule

// ----- rtl/exposure_sweep_frame_averager.sv -----
// Pipeline: an accepted pixel passes the stage-one register, the store read, four divide
// stages of four quotient bits each and the output register before its result appears.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits
// on m_tready, with the sum-store read port fed from stage one.
// Reset: rst is synchronous; it clears valids, frame state and registers to
// their defaults. The sum store is not cleared; its first frame writes it.
module exposure_sweep_frame_averager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_bgr
  input  logic        s_tlast,   // end_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // average_bgr, exposure_used, next_exposure, sweep_done
  output logic        m_tlast,   // last_of_image
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import esfa_pkg::*;

  logic en, v1, sv;
  ctl_t c1;
  logic [47:0] sums;
  tag_t tag;
  logic [23:0] avg;
  meta_t meta;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  esfa_ctrl u_ctrl (
    .clk, .rst, .en, .in_valid(s_tvalid), .pixel_bgr(s_tdata), .end_of_frame(s_tlast),
    .cfg_we, .cfg_index, .cfg_data, .v1, .c1
  );

  esfa_accum u_accum (
    .clk, .rst, .en, .v1, .c1, .sum_valid(sv), .sums, .tag
  );

  esfa_div u_div (
    .clk, .rst, .en, .in_valid(sv), .sums, .tag_in(tag),
    .out_valid(m_tvalid), .avg, .meta
  );

  assign m_tdata = {6'd0, meta.sweep_done, meta.next_exposure, meta.exposure_used, avg};
  assign m_tlast = meta.last_of_image;
endmodule

// ----- rtl/esfa_checker.sv -----
// Port-level assertions for the exposure sweep frame averager.
`include "exposure_sweep_frame_averager_defines.svh"
module esfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);
  `ESFA_ASSERT_NOW(a_ready_follows, clk, rst, m_tready, s_tready)
  `ESFA_ASSERT_NOW(a_next_only_last, clk, rst, m_tvalid && !m_tlast, m_tdata[65:44] == 22'd0)
  `ESFA_ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid)
  `ESFA_ASSERT_NEXT(a_hold, clk, !rst && m_tvalid && !m_tready,
                    rst || (m_tvalid && $stable(m_tdata)))
endmodule

bind exposure_sweep_frame_averager esfa_checker u_esfa_checker (.*);
